@@ hw/rtl/qoi_chunk_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// QOI chunk decoder assertion macros
// Shared concurrent-check wrappers for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef QOI_CHUNK_DECODER_DEFINES_SVH
`define QOI_CHUNK_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QCD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("qoi_chunk_decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QCD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("qoi_chunk_decoder check failed");

`endif

@@ hw/rtl/qcd_pkg.sv @@
// ----------------------------------------------------------------------------
// QOI chunk decoder package
// Op codes, tag constants and the color hash shared by the decoder.
// ----------------------------------------------------------------------------
package qcd_pkg;

    localparam int INDEX_SIZE = 64;
    localparam int HASH_W     = 13;

    localparam logic [31:0] PREV_RESET = 32'h0000_00FF;

    localparam logic [7:0] TAG_RGB  = 8'hFE;
    localparam logic [7:0] TAG_RGBA = 8'hFF;

    // Two-bit op field in the top of a tag byte
    localparam logic [1:0] OP2_INDEX = 2'b00;
    localparam logic [1:0] OP2_DIFF  = 2'b01;
    localparam logic [1:0] OP2_LUMA  = 2'b10;
    localparam logic [1:0] OP2_RUN   = 2'b11;

    localparam logic [2:0] LEFT_RGB  = 3'd3;
    localparam logic [2:0] LEFT_RGBA = 3'd4;
    localparam logic [2:0] LEFT_LUMA = 3'd1;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_RGB  = 2'd1,
        OP_RGBA = 2'd2,
        OP_LUMA = 2'd3
    } op_t;

    // r*3 + g*5 + b*7 + a*11, full sum; callers keep the low index bits
    function automatic logic [HASH_W-1:0] px_hash_sum(input logic [31:0] px);
        logic [HASH_W-1:0] r;
        logic [HASH_W-1:0] g;
        logic [HASH_W-1:0] b;
        logic [HASH_W-1:0] a;
        r = HASH_W'(px[31:24]);
        g = HASH_W'(px[23:16]);
        b = HASH_W'(px[15:8]);
        a = HASH_W'(px[7:0]);
        return r * HASH_W'(3) + g * HASH_W'(5) + b * HASH_W'(7) + a * HASH_W'(11);
    endfunction

endpackage

@@ hw/rtl/qoi_chunk_decoder.sv @@
// ----------------------------------------------------------------------------
// QOI chunk decoder
// Decodes the QOI chunk byte stream (after the header) into RGBA pixels.
// ----------------------------------------------------------------------------
// Takes one stream byte per input word and returns decoded RGBA pixels, one
// per output word, with m_run_last set on the final pixel a byte produces.
// Raise s_start_image with the first chunk byte of an image: it clears the
// color index, sets the previous pixel to black with alpha 255 and drops any
// half-collected op. End markers are not detected; they decode as INDEX ops.
// The color index lives in a 64-entry RAM with registered read; a row of
// per-entry valid flops (cleared by reset and by start) makes unwritten
// entries read as zero, so no clearing pass is needed. A tag or operand byte
// that yields no pixel returns straight to idle; RGB/RGBA/LUMA final bytes,
// DIFF and run bytes go to the emit state; INDEX goes through accept, index
// RAM read and emit. A run of n pixels leaves one pixel per cycle through the
// output register while the output side is ready. The input is held off
// while a byte is being emitted; the next byte is taken while the last pixel
// still waits in the output register.
// ----------------------------------------------------------------------------
`include "qoi_chunk_decoder_defines.svh"

module qoi_chunk_decoder #(
    parameter int INDEX_SIZE = qcd_pkg::INDEX_SIZE
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input words: one stream byte each
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_start_image,
    // output words: one pixel each
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue,
    output logic [7:0] m_alpha,
    output logic       m_run_last
);

    localparam int AW = $clog2(INDEX_SIZE);

    typedef enum logic [1:0] {
        ST_IDLE,    // wait for a byte
        ST_READ,    // index RAM read in flight
        ST_EMIT     // push pixel(s) out, update index and previous pixel
    } state_t;

    state_t          state_reg,  state_next;
    logic [31:0]     prev_reg,   prev_next;
    qcd_pkg::op_t    pend_reg,   pend_next;
    logic [2:0]      left_reg,   left_next;
    logic [23:0]     coll_reg,   coll_next;
    logic [31:0]     px_reg,     px_next;
    logic [5:0]      run_reg,    run_next;
    logic [AW-1:0]   idx_reg,    idx_next;
    logic [INDEX_SIZE-1:0] valid_reg, valid_next;
    logic            mval_reg,   mval_next;
    logic [31:0]     mpx_reg,    mpx_next;
    logic            mlast_reg,  mlast_next;

    // effective state after an optional start
    logic [31:0]     prev_eff;
    qcd_pkg::op_t    pend_eff;
    logic [2:0]      left_eff;
    logic [23:0]     coll_eff;

    logic            accept;
    logic            out_free;
    logic [7:0]      vg;
    logic [7:0]      luma_r;
    logic [7:0]      luma_g;
    logic [7:0]      luma_b;
    logic [7:0]      diff_r;
    logic [7:0]      diff_g;
    logic [7:0]      diff_b;
    logic [AW-1:0]   hash;

    logic            ram_we;
    logic            ram_re;
    logic [31:0]     ram_rdata;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !mval_reg || m_ready;

    assign prev_eff = s_start_image ? qcd_pkg::PREV_RESET : prev_reg;
    assign pend_eff = s_start_image ? qcd_pkg::OP_NONE : pend_reg;
    assign left_eff = s_start_image ? 3'd0 : left_reg;
    assign coll_eff = s_start_image ? 24'd0 : coll_reg;

    // LUMA: green delta from the tag byte, red/blue offsets from this byte
    assign vg     = {2'b00, coll_eff[5:0]} - 8'd32;
    assign luma_r = prev_eff[31:24] + vg + {4'b0000, s_data_byte[7:4]} - 8'd8;
    assign luma_g = prev_eff[23:16] + vg;
    assign luma_b = prev_eff[15:8]  + vg + {4'b0000, s_data_byte[3:0]} - 8'd8;

    // DIFF: each channel moves by -2..+1
    assign diff_r = prev_eff[31:24] + {6'b0, s_data_byte[5:4]} - 8'd2;
    assign diff_g = prev_eff[23:16] + {6'b0, s_data_byte[3:2]} - 8'd2;
    assign diff_b = prev_eff[15:8]  + {6'b0, s_data_byte[1:0]} - 8'd2;

    // index slot of the pixel being emitted (power-of-two modulo)
    assign hash = AW'(qcd_pkg::px_hash_sum(px_reg));

    // Reads are issued only from idle and writes only while emitting, so
    // the two never meet in one cycle and a read always sees earlier writes.
    assign ram_we = (state_reg == ST_EMIT);
    assign ram_re = accept && !(pend_eff != qcd_pkg::OP_NONE && left_eff != 3'd0)
                    && s_data_byte != qcd_pkg::TAG_RGB
                    && s_data_byte != qcd_pkg::TAG_RGBA
                    && s_data_byte[7:6] == qcd_pkg::OP2_INDEX;

    qcd_ram #(
        .WIDTH (32),
        .DEPTH (INDEX_SIZE)
    ) u_index_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (hash),
        .wdata (px_reg),
        .re    (ram_re),
        .raddr (s_data_byte[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        prev_next  = prev_reg;
        pend_next  = pend_reg;
        left_next  = left_reg;
        coll_next  = coll_reg;
        px_next    = px_reg;
        run_next   = run_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        mval_next  = mval_reg && !m_ready;
        mpx_next   = mpx_reg;
        mlast_next = mlast_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_start_image) begin
                        valid_next = '0;
                        prev_next  = qcd_pkg::PREV_RESET;
                    end
                    if (pend_eff != qcd_pkg::OP_NONE && left_eff != 3'd0) begin
                        if (left_eff > 3'd1) begin
                            // collect an operand byte, no pixel yet
                            pend_next = pend_eff;
                            coll_next = {coll_eff[15:0], s_data_byte};
                            left_next = left_eff - 3'd1;
                        end else begin
                            // final byte of a multi-byte op
                            pend_next  = qcd_pkg::OP_NONE;
                            left_next  = 3'd0;
                            coll_next  = 24'd0;
                            run_next   = 6'd0;
                            state_next = ST_EMIT;
                            case (pend_eff)
                                qcd_pkg::OP_LUMA: px_next = {luma_r, luma_g, luma_b,
                                                             prev_eff[7:0]};
                                qcd_pkg::OP_RGB:  px_next = {coll_eff[15:0], s_data_byte,
                                                             prev_eff[7:0]};
                                default:          px_next = {coll_eff, s_data_byte};
                            endcase
                        end
                    end else begin
                        pend_next = qcd_pkg::OP_NONE;
                        left_next = 3'd0;
                        coll_next = 24'd0;
                        run_next  = 6'd0;
                        if (s_data_byte == qcd_pkg::TAG_RGB) begin
                            pend_next = qcd_pkg::OP_RGB;
                            left_next = qcd_pkg::LEFT_RGB;
                        end else if (s_data_byte == qcd_pkg::TAG_RGBA) begin
                            pend_next = qcd_pkg::OP_RGBA;
                            left_next = qcd_pkg::LEFT_RGBA;
                        end else begin
                            unique case (s_data_byte[7:6])
                                qcd_pkg::OP2_INDEX: begin
                                    idx_next   = s_data_byte[AW-1:0];
                                    state_next = ST_READ;
                                end
                                qcd_pkg::OP2_DIFF: begin
                                    px_next    = {diff_r, diff_g, diff_b, prev_eff[7:0]};
                                    state_next = ST_EMIT;
                                end
                                qcd_pkg::OP2_LUMA: begin
                                    pend_next = qcd_pkg::OP_LUMA;
                                    left_next = qcd_pkg::LEFT_LUMA;
                                    coll_next = {16'd0, s_data_byte};
                                end
                                default: begin
                                    // run: repeat the previous pixel
                                    px_next    = prev_eff;
                                    run_next   = s_data_byte[5:0];
                                    state_next = ST_EMIT;
                                end
                            endcase
                        end
                    end
                end
            end
            ST_READ: begin
                // unwritten entries since the last start read as zero
                px_next    = valid_reg[idx_reg] ? ram_rdata : 32'd0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // rewriting the same entry on every run pixel is harmless
                prev_next        = px_reg;
                valid_next[hash] = 1'b1;
                if (out_free) begin
                    mval_next  = 1'b1;
                    mpx_next   = px_reg;
                    mlast_next = (run_reg == 6'd0);
                    if (run_reg == 6'd0) begin
                        state_next = ST_IDLE;
                    end else begin
                        run_next = run_reg - 6'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            prev_reg  <= qcd_pkg::PREV_RESET;
            pend_reg  <= qcd_pkg::OP_NONE;
            left_reg  <= 3'd0;
            coll_reg  <= 24'd0;
            run_reg   <= 6'd0;
            valid_reg <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
            pend_reg  <= pend_next;
            left_reg  <= left_next;
            coll_reg  <= coll_next;
            run_reg   <= run_next;
            valid_reg <= valid_next;
            mval_reg  <= mval_next;
        end
        px_reg    <= px_next;
        idx_reg   <= idx_next;
        mpx_reg   <= mpx_next;
        mlast_reg <= mlast_next;
    end

    assign m_valid    = mval_reg;
    assign m_red      = mpx_reg[31:24];
    assign m_green    = mpx_reg[23:16];
    assign m_blue     = mpx_reg[15:8];
    assign m_alpha    = mpx_reg[7:0];
    assign m_run_last = mlast_reg;

    // A pending op always has operand bytes still to come
    `QCD_ASSERT_IMP(a_pend_has_left, aclk, aresetn,
        pend_reg != qcd_pkg::OP_NONE, left_reg != 3'd0)
    // Index RAM read and write never share a cycle
    `QCD_ASSERT_IMP(a_ram_no_overlap, aclk, aresetn, ram_we, !ram_re)
    // Read data is consumed in the cycle after the read
    `QCD_ASSERT_NXT(a_read_to_emit, aclk, aresetn,
        state_reg == ST_READ, state_reg == ST_EMIT)
    // The last pixel of a byte returns the decoder to idle
    `QCD_ASSERT_NXT(a_last_to_idle, aclk, aresetn,
        state_reg == ST_EMIT && out_free && run_reg == 6'd0,
        state_reg == ST_IDLE && mval_reg && mlast_reg)

endmodule

@@ hw/rtl/qcd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module qcd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
